// ----- sv/asr_pkg.sv -----
// Shared types and constants for the adaptive-slice round-robin scheduler.
// Holds the word formats, command codes and exhaustion marks.
// No dependencies.
package asr_pkg;

    localparam int CMD_W     = 3;
    localparam int TASK_ID_W = 4;
    localparam int WORK_W    = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int MARK_W    = 2;

    localparam int NUM_TASKS_DEF  = 16;
    localparam int SLICE_BITS_DEF = 8;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PICK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEAL    = 3'd4;

    localparam logic [MARK_W-1:0] MARK_EARLY     = 2'd0;
    localparam logic [MARK_W-1:0] MARK_EXHAUSTED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_UNKNOWN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_QUANTUM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLICE       = 1'd1;

    localparam logic [CFG_W-1:0] INITIAL_QUANTUM_RST = 8'd3;
    localparam logic [CFG_W-1:0] MAX_SLICE_RST       = 8'd5;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [TASK_ID_W-1:0] task_id;
        logic                 task_is_idle;
        logic                 task_on_queue;
        logic [WORK_W-1:0]    work_ticks_left;
    } req_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] out_task;
        logic                 out_valid;
        logic                 resched;
    } rsp_t;

    typedef struct packed {
        logic we;
        logic resched;
    } upd_ctl_t;

endpackage

// ----- sv/asr_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the per-task table and the run queue slots.
// No dependencies.
module asr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/asr_task_upd.sv -----
// Read-modify-write logic for one per-task table entry.
// Computes slice adaptation, tick charging and the exhaustion mark.
// Depends on asr_pkg.
module asr_task_upd #(
    parameter int SLICE_BITS = asr_pkg::SLICE_BITS_DEF
) (
    input  logic [asr_pkg::CMD_W-1:0]  cmd,
    input  logic                       task_is_idle,
    input  logic                       task_on_queue,
    input  logic [asr_pkg::WORK_W-1:0] work_ticks_left,
    input  logic [SLICE_BITS-1:0]      init_quantum,
    input  logic [SLICE_BITS-1:0]      max_slice,
    input  logic [SLICE_BITS-1:0]      cur_slice,
    input  logic [SLICE_BITS-1:0]      cur_ticks,
    input  logic [asr_pkg::MARK_W-1:0] cur_mark,
    input  logic [SLICE_BITS-1:0]      cur_tmax,
    output logic [SLICE_BITS-1:0]      new_slice,
    output logic [SLICE_BITS-1:0]      new_ticks,
    output logic [asr_pkg::MARK_W-1:0] new_mark,
    output logic [SLICE_BITS-1:0]      new_tmax,
    output asr_pkg::upd_ctl_t          ctl
);
    import asr_pkg::*;

    localparam logic [SLICE_BITS-1:0] ONE = SLICE_BITS'(1);

    logic [SLICE_BITS-1:0] adj_slice;
    logic [SLICE_BITS-1:0] dec_ticks;

    always_comb
    begin
        adj_slice = cur_slice;
        if (cur_mark == MARK_EXHAUSTED && cur_slice > ONE)
        begin
            adj_slice = cur_slice - ONE;
        end
        else if (cur_mark == MARK_EARLY && cur_slice < cur_tmax)
        begin
            adj_slice = cur_slice + ONE;
        end
        // The remaining count saturates at zero.
        dec_ticks = (cur_ticks != '0) ? cur_ticks - ONE : '0;
    end

    always_comb
    begin
        new_slice   = cur_slice;
        new_ticks   = cur_ticks;
        new_mark    = cur_mark;
        new_tmax    = cur_tmax;
        ctl.we      = 1'b0;
        ctl.resched = 1'b0;
        case (cmd)
            CMD_REGISTER:
            begin
                new_slice = init_quantum;
                new_ticks = init_quantum;
                new_mark  = MARK_UNKNOWN;
                new_tmax  = max_slice;
                ctl.we    = 1'b1;
            end
            CMD_ENQUEUE:
            begin
                if (!task_on_queue && !task_is_idle)
                begin
                    new_slice = adj_slice;
                    new_ticks = adj_slice;
                    ctl.we    = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (!task_is_idle)
                begin
                    new_ticks = dec_ticks;
                    new_mark  = MARK_EARLY;
                    ctl.we    = 1'b1;
                    if (dec_ticks == '0)
                    begin
                        if (work_ticks_left > WORK_W'(1))
                        begin
                            new_mark = MARK_EXHAUSTED;
                        end
                        ctl.resched = 1'b1;
                    end
                end
            end
            default:
            begin
                ctl.we = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/adaptive_slice_round_robin.sv -----
// Top level of the adaptive-slice round-robin scheduler.
// Instantiates asr_ram (task table, queue slots) and asr_task_upd; uses asr_pkg.
//
//   Channel  | Signals                      | Direction | Word
//   ---------+------------------------------+-----------+------------------
//   request  | req_valid, req_stall, req    | in        | asr_pkg::req_t
//   response | rsp_valid, rsp_stall, rsp    | out       | asr_pkg::rsp_t
//   config   | cfg_we, cfg_index, cfg_data  | in        | 8-bit register
//
// Each word is handled in order: the accept cycle reads the task table and the
// queue slot memory, then the execute state modifies and writes back and loads the
// response register. One word is in flight at a time, so no forwarding is needed.
// Reset clears the queue pointers and restores the configuration defaults;
// the memories start undefined. A stalled response holds the execute cycle,
// and req_stall stays high until that word has moved into the response register.
module adaptive_slice_round_robin #(
    parameter int NUM_TASKS  = asr_pkg::NUM_TASKS_DEF,
    parameter int SLICE_BITS = asr_pkg::SLICE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  asr_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output asr_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [asr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [asr_pkg::CFG_W-1:0]     cfg_data
);
    import asr_pkg::*;

    localparam int TW = $clog2(NUM_TASKS);
    localparam int QW = TW + 2;
    localparam int EW = 3 * SLICE_BITS + MARK_W;
    localparam int CW = CFG_W + SLICE_BITS;
    localparam logic [SLICE_BITS-1:0] SLICE_MAX = '1;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    function automatic logic [TW-1:0] tid_index(input logic [TASK_ID_W-1:0] t);
        logic [TW-1:0] r;
        r = '0;
        for (int k = 0; k < 2 ** TASK_ID_W; k++)
        begin
            if (t == TASK_ID_W'(k))
            begin
                r = TW'(k % NUM_TASKS);
            end
        end
        return r;
    endfunction

    function automatic logic [SLICE_BITS-1:0] clamp_slice(input logic [CFG_W-1:0] v);
        logic [SLICE_BITS-1:0] r;
        r = (CW'(v) > CW'(SLICE_MAX)) ? SLICE_MAX : SLICE_BITS'(v);
        return r;
    endfunction

    state_t                state_reg;
    req_t                  item_reg;
    logic [TW-1:0]         idx_reg;
    logic [TW-1:0]         queue_head_reg;
    logic [TW:0]           queue_count_reg;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg;
    logic [CFG_W-1:0]      init_quantum_reg;
    logic [CFG_W-1:0]      max_slice_reg;

    logic                  accept;
    logic                  fire;
    logic [QW-1:0]         tail_sum;
    logic [QW-1:0]         last_sum;
    logic [TW-1:0]         tail_idx;
    logic [TW-1:0]         last_idx;
    logic [TW-1:0]         slot_raddr;
    logic [TASK_ID_W-1:0]  slot_rdata;
    logic                  slot_we;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  is_enq;
    logic                  is_take;
    logic [TW-1:0]         head_inc;

    logic [EW-1:0]         tbl_rdata;
    logic [EW-1:0]         tbl_wdata;
    logic                  tbl_we;
    logic [SLICE_BITS-1:0] new_slice;
    logic [SLICE_BITS-1:0] new_ticks;
    logic [MARK_W-1:0]     new_mark;
    logic [SLICE_BITS-1:0] new_tmax;
    upd_ctl_t              upd_ctl;
    rsp_t                  rsp_next;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign fire      = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Queue index arithmetic: sums stay below twice the depth, so one
    // conditional subtract wraps them.
    always_comb
    begin
        queue_full  = (queue_count_reg == (TW + 1)'(NUM_TASKS));
        queue_empty = (queue_count_reg == '0);
        tail_sum    = QW'(queue_head_reg) + QW'(queue_count_reg);
        last_sum    = tail_sum - QW'(1);
        tail_idx    = (tail_sum >= QW'(NUM_TASKS)) ? TW'(tail_sum - QW'(NUM_TASKS))
                                                   : TW'(tail_sum);
        last_idx    = (last_sum >= QW'(NUM_TASKS)) ? TW'(last_sum - QW'(NUM_TASKS))
                                                   : TW'(last_sum);
        head_inc    = ((TW + 1)'(queue_head_reg) + (TW + 1)'(1) == (TW + 1)'(NUM_TASKS))
                      ? '0 : queue_head_reg + TW'(1);
        slot_raddr  = (req.cmd == CMD_STEAL && !queue_empty) ? last_idx : queue_head_reg;
    end

    asr_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (idx_reg),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (tid_index(req.task_id)),
        .rdata (tbl_rdata)
    );

    asr_ram #(
        .WIDTH (TASK_ID_W),
        .DEPTH (NUM_TASKS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (tail_idx),
        .wdata (TASK_ID_W'(idx_reg)),
        .re    (accept),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    asr_task_upd #(
        .SLICE_BITS (SLICE_BITS)
    ) u_task_upd (
        .cmd             (item_reg.cmd),
        .task_is_idle    (item_reg.task_is_idle),
        .task_on_queue   (item_reg.task_on_queue),
        .work_ticks_left (item_reg.work_ticks_left),
        .init_quantum    (clamp_slice(init_quantum_reg)),
        .max_slice       (clamp_slice(max_slice_reg)),
        .cur_slice       (tbl_rdata[EW-1 -: SLICE_BITS]),
        .cur_ticks       (tbl_rdata[EW-SLICE_BITS-1 -: SLICE_BITS]),
        .cur_mark        (tbl_rdata[SLICE_BITS +: MARK_W]),
        .cur_tmax        (tbl_rdata[SLICE_BITS-1:0]),
        .new_slice       (new_slice),
        .new_ticks       (new_ticks),
        .new_mark        (new_mark),
        .new_tmax        (new_tmax),
        .ctl             (upd_ctl)
    );

    always_comb
    begin
        tbl_wdata = {new_slice, new_ticks, new_mark, new_tmax};
        tbl_we    = fire && upd_ctl.we;
        is_enq    = (item_reg.cmd == CMD_ENQUEUE)
                    && !item_reg.task_on_queue && !item_reg.task_is_idle;
        is_take   = (item_reg.cmd == CMD_PICK || item_reg.cmd == CMD_STEAL) && !queue_empty;
        slot_we   = fire && is_enq && !queue_full;
        rsp_next.out_valid = is_take;
        rsp_next.out_task  = is_take ? slot_rdata : '0;
        rsp_next.resched   = upd_ctl.resched;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            idx_reg         <= '0;
            queue_head_reg  <= '0;
            queue_count_reg <= '0;
            rsp_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !fire)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= req;
                        idx_reg   <= tid_index(req.task_id);
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (slot_we)
                        begin
                            queue_count_reg <= queue_count_reg + (TW + 1)'(1);
                        end
                        else if (is_take)
                        begin
                            queue_count_reg <= queue_count_reg - (TW + 1)'(1);
                            if (item_reg.cmd == CMD_PICK)
                            begin
                                queue_head_reg <= head_inc;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_quantum_reg <= INITIAL_QUANTUM_RST;
            max_slice_reg    <= MAX_SLICE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INITIAL_QUANTUM: init_quantum_reg <= cfg_data;
                CFG_MAX_SLICE:       max_slice_reg    <= cfg_data;
                default:             init_quantum_reg <= init_quantum_reg;
            endcase
        end
    end

endmodule
